>>> hdl/bpp_pkg.sv
// Shared types, constants and fixed-point helpers for the Boris particle push core.
// No dependencies; every other file refers to this package by scoped names.
package bpp_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [2:0] vec_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_CHARGE     = 2'd1;
  localparam logic [1:0] REG_MASS       = 2'd2;
  localparam logic [1:0] REG_ACCEL_UNIT = 2'd3;

  localparam logic [30:0] TIME_STEP_RST  = 31'd6554;
  localparam logic [31:0] CHARGE_RST     = 32'd65536;
  localparam logic [30:0] MASS_RST       = 31'd65536;
  localparam logic [30:0] ACCEL_UNIT_RST = 31'd65536;

  // Rotation factor 2/(1+|t|^2): numerator 2^49, quotient fits in 18 bits
  localparam int          DIV_BITS = 18;
  localparam logic [63:0] FAC_NUM  = 64'h0002_0000_0000_0000;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic        busy;
    logic [30:0] time_step;
    word_t       qp;
  } cfg_t;

  // Values carried alongside the rotation-factor divider
  typedef struct packed {
    vec_t pos;
    vec_t kick;
    vec_t t;
    vec_t vm;
    vec_t vi;
  } side_t;

  typedef struct packed {
    vec_t np;
    vec_t vn;
    vec_t st;
  } res_t;

  function automatic logic signed [63:0] mul32s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic word_t sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -80'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Round half up and drop 16 fraction bits
  function automatic logic signed [79:0] rnd16(input logic signed [79:0] p);
    return (p + 80'sd32768) >>> 16;
  endfunction

  function automatic word_t qmul(input logic signed [63:0] p);
    return sat32(rnd16(80'(p)));
  endfunction

endpackage

>>> hdl/bpp_qp_unit.sv
// Configuration registers and the charge-to-mass scale qp, recomputed after each write.
// Depends on bpp_pkg (types, register indexes, fixed-point helpers).
module bpp_qp_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output bpp_pkg::cfg_t    cfg
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SAT, ST_PROD, ST_FIN} state_t;

  state_t                state;
  logic [30:0]           time_step;
  logic [31:0]           charge;
  logic [30:0]           mass;
  logic [30:0]           accel_unit;
  logic                  neg;
  logic [63:0]           dvd;
  logic [31:0]           dvs;
  logic [31:0]           rem;
  logic [5:0]            cnt;
  logic signed [31:0]    qp0;
  logic signed [63:0]    prod;
  bpp_pkg::word_t        qp;

  logic signed [63:0]    num;
  logic [63:0]           mag;
  logic [31:0]           mass_eff;
  logic [32:0]           rem2;
  logic                  ge;

  always_comb begin
    num      = bpp_pkg::mul32s($signed({1'b0, time_step}), $signed(charge));
    mag      = num[63] ? 64'(-num) : 64'(num);
    mass_eff = (mass == 31'd0) ? 32'd1 : {1'b0, mass};
    rem2     = {rem, dvd[63]};
    ge       = rem2 >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_MUL;
      time_step  <= bpp_pkg::TIME_STEP_RST;
      charge     <= bpp_pkg::CHARGE_RST;
      mass       <= bpp_pkg::MASS_RST;
      accel_unit <= bpp_pkg::ACCEL_UNIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bpp_pkg::REG_TIME_STEP:  time_step  <= cfg_data[30:0];
        bpp_pkg::REG_CHARGE:     charge     <= cfg_data;
        bpp_pkg::REG_MASS:       mass       <= cfg_data[30:0];
        bpp_pkg::REG_ACCEL_UNIT: accel_unit <= cfg_data[30:0];
        default:                 charge     <= charge;
      endcase
      state <= ST_MUL;
    end else begin
      case (state)
        ST_MUL: begin
          neg   <= num[63];
          dvd   <= mag + 64'(mass_eff);
          dvs   <= {mass_eff[30:0], 1'b0};
          rem   <= 32'd0;
          cnt   <= 6'd0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= ge ? 32'(rem2 - {1'b0, dvs}) : rem2[31:0];
          dvd <= {dvd[62:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (neg) begin
            qp0 <= (dvd > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-dvd[31:0]);
          end else begin
            qp0 <= (dvd > 64'h7fff_ffff) ? 32'sh7fff_ffff : dvd[31:0];
          end
          state <= ST_PROD;
        end
        ST_PROD: begin
          prod  <= bpp_pkg::mul32s(qp0, $signed({1'b0, accel_unit}));
          state <= ST_FIN;
        end
        ST_FIN: begin
          qp    <= bpp_pkg::qmul(prod);
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign cfg.busy      = (state != ST_IDLE);
  assign cfg.time_step = time_step;
  assign cfg.qp        = qp;

endmodule

>>> hdl/bpp_front.sv
// Front stages: half kick, t = qp*B, |t|^2 and the first rotation v' = v- + v- x t.
// Depends on bpp_pkg (vectors, side payload, fixed-point helpers).
module bpp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  bpp_pkg::vec_t      pos,
  input  bpp_pkg::vec_t      vel,
  input  bpp_pkg::vec_t      ef,
  input  bpp_pkg::vec_t      bf,
  input  bpp_pkg::word_t     qp,
  output logic               f_valid,
  output logic [63:0]        f_num,
  output logic [63:0]        f_den,
  output bpp_pkg::side_t     f_side
);

  logic               f1_v, f2_v, f3_v, f4_v;
  logic signed [63:0] f1_tb [3];
  logic signed [63:0] f1_ke [3];
  bpp_pkg::vec_t      f1_pos, f1_vel;
  bpp_pkg::vec_t      f2_t, f2_kick, f2_pos, f2_vel;
  logic signed [63:0] f3_tt [3];
  bpp_pkg::vec_t      f3_vm, f3_t, f3_kick, f3_pos;
  logic [63:0]        f4_den;
  logic signed [63:0] f4_c1 [3];
  logic signed [63:0] f4_c2 [3];
  bpp_pkg::vec_t      f4_vm, f4_t, f4_kick, f4_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0; f2_v <= 1'b0; f3_v <= 1'b0; f4_v <= 1'b0; f_valid <= 1'b0;
    end else if (en) begin
      f1_v <= in_valid; f2_v <= f1_v; f3_v <= f2_v; f4_v <= f3_v; f_valid <= f4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products with qp
      for (int i = 0; i < 3; i++) begin
        f1_tb[i] <= bpp_pkg::mul32s($signed(qp), $signed(bf[i]));
        f1_ke[i] <= bpp_pkg::mul32s($signed(qp), $signed(ef[i]));
      end
      f1_pos <= pos;
      f1_vel <= vel;
      // round t and kick
      for (int i = 0; i < 3; i++) begin
        f2_t[i]    <= bpp_pkg::qmul(f1_tb[i]);
        f2_kick[i] <= bpp_pkg::qmul(f1_ke[i]);
      end
      f2_pos <= f1_pos;
      f2_vel <= f1_vel;
      // squares of t, first half kick
      for (int i = 0; i < 3; i++) begin
        f3_tt[i] <= bpp_pkg::mul32s($signed(f2_t[i]), $signed(f2_t[i]));
        f3_vm[i] <= bpp_pkg::sat32(80'($signed(f2_vel[i])) + 80'($signed(f2_kick[i])));
      end
      f3_t    <= f2_t;
      f3_kick <= f2_kick;
      f3_pos  <= f2_pos;
      // 1 + |t|^2 and cross products v- x t
      f4_den   <= bpp_pkg::ONE_Q32 + 64'(f3_tt[0]) + 64'(f3_tt[1]) + 64'(f3_tt[2]);
      f4_c1[0] <= bpp_pkg::mul32s($signed(f3_vm[1]), $signed(f3_t[2]));
      f4_c2[0] <= bpp_pkg::mul32s($signed(f3_vm[2]), $signed(f3_t[1]));
      f4_c1[1] <= bpp_pkg::mul32s($signed(f3_vm[2]), $signed(f3_t[0]));
      f4_c2[1] <= bpp_pkg::mul32s($signed(f3_vm[0]), $signed(f3_t[2]));
      f4_c1[2] <= bpp_pkg::mul32s($signed(f3_vm[0]), $signed(f3_t[1]));
      f4_c2[2] <= bpp_pkg::mul32s($signed(f3_vm[1]), $signed(f3_t[0]));
      f4_vm   <= f3_vm;
      f4_t    <= f3_t;
      f4_kick <= f3_kick;
      f4_pos  <= f3_pos;
      // first rotation and divider operands
      for (int i = 0; i < 3; i++) begin
        f_side.vi[i] <= bpp_pkg::sat32(80'($signed(f4_vm[i]))
                        + bpp_pkg::rnd16(80'(f4_c1[i]) - 80'(f4_c2[i])));
      end
      f_num       <= bpp_pkg::FAC_NUM + (f4_den >> 1);
      f_den       <= f4_den;
      f_side.vm   <= f4_vm;
      f_side.t    <= f4_t;
      f_side.kick <= f4_kick;
      f_side.pos  <= f4_pos;
    end
  end

endmodule

>>> hdl/bpp_fac_div.sv
// Pipelined restoring divider for the rotation factor, one quotient bit per stage.
// Depends on bpp_pkg (DIV_BITS, side payload carried next to the quotient).
module bpp_fac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           d_in_valid,
  input  logic [63:0]                    num,
  input  logic [63:0]                    den,
  input  bpp_pkg::side_t                 d_in_side,
  output logic                           d_valid,
  output logic [bpp_pkg::DIV_BITS-1:0]   fac,
  output bpp_pkg::side_t                 d_side
);

  localparam int N = bpp_pkg::DIV_BITS;

  logic                 v_q   [0:N];
  logic [63:0]          rem_q [0:N];
  logic [N-1:0]         nlo_q [0:N];
  logic [N-1:0]         quo_q [0:N];
  logic [63:0]          den_q [0:N];
  bpp_pkg::side_t       sd_q  [0:N];

  // Quotient stays below 2^N, so the top of the dividend is already below den
  assign v_q[0]   = d_in_valid;
  assign rem_q[0] = num >> N;
  assign nlo_q[0] = num[N-1:0];
  assign quo_q[0] = '0;
  assign den_q[0] = den;
  assign sd_q[0]  = d_in_side;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [64:0] rem2;
    logic        ge;
    assign rem2 = {rem_q[k], nlo_q[k][N-1]};
    assign ge   = rem2 >= {1'b0, den_q[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? 64'(rem2 - {1'b0, den_q[k]}) : rem2[63:0];
        nlo_q[k+1] <= {nlo_q[k][N-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][N-2:0], ge};
        den_q[k+1] <= den_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  assign d_valid = v_q[N];
  assign fac     = quo_q[N];
  assign d_side  = sd_q[N];

endmodule

>>> hdl/bpp_back.sv
// Back stages: s = fac*t, second rotation, second half kick, drift and step.
// Depends on bpp_pkg (vectors, side payload, result word, fixed-point helpers).
module bpp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          b_in_valid,
  input  logic [bpp_pkg::DIV_BITS-1:0]  fac,
  input  bpp_pkg::side_t                side,
  input  logic [30:0]                   time_step,
  output logic                          b_valid,
  output bpp_pkg::res_t                 b_res
);

  logic               b1_v, b2_v, b3_v, b4_v, b5_v, b6_v, b7_v;
  logic signed [63:0] b1_p [3];
  bpp_pkg::side_t     b1_sd;
  bpp_pkg::vec_t      b2_s;
  bpp_pkg::side_t     b2_sd;
  logic signed [63:0] b3_c1 [3];
  logic signed [63:0] b3_c2 [3];
  bpp_pkg::vec_t      b3_vm, b3_kick, b3_pos;
  bpp_pkg::vec_t      b4_vp, b4_kick, b4_pos;
  bpp_pkg::vec_t      b5_vn, b5_pos;
  logic signed [63:0] b6_p [3];
  bpp_pkg::vec_t      b6_vn, b6_pos;
  bpp_pkg::vec_t      b7_np, b7_vn, b7_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0; b2_v <= 1'b0; b3_v <= 1'b0; b4_v <= 1'b0;
      b5_v <= 1'b0; b6_v <= 1'b0; b7_v <= 1'b0; b_valid <= 1'b0;
    end else if (en) begin
      b1_v <= b_in_valid; b2_v <= b1_v; b3_v <= b2_v; b4_v <= b3_v;
      b5_v <= b4_v; b6_v <= b5_v; b7_v <= b6_v; b_valid <= b7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1_p[i] <= bpp_pkg::mul32s($signed(32'(fac)), $signed(side.t[i]));
      end
      b1_sd <= side;
      for (int i = 0; i < 3; i++) begin
        b2_s[i] <= bpp_pkg::qmul(b1_p[i]);
      end
      b2_sd <= b1_sd;
      // v' x s
      b3_c1[0] <= bpp_pkg::mul32s($signed(b2_sd.vi[1]), $signed(b2_s[2]));
      b3_c2[0] <= bpp_pkg::mul32s($signed(b2_sd.vi[2]), $signed(b2_s[1]));
      b3_c1[1] <= bpp_pkg::mul32s($signed(b2_sd.vi[2]), $signed(b2_s[0]));
      b3_c2[1] <= bpp_pkg::mul32s($signed(b2_sd.vi[0]), $signed(b2_s[2]));
      b3_c1[2] <= bpp_pkg::mul32s($signed(b2_sd.vi[0]), $signed(b2_s[1]));
      b3_c2[2] <= bpp_pkg::mul32s($signed(b2_sd.vi[1]), $signed(b2_s[0]));
      b3_vm   <= b2_sd.vm;
      b3_kick <= b2_sd.kick;
      b3_pos  <= b2_sd.pos;
      for (int i = 0; i < 3; i++) begin
        b4_vp[i] <= bpp_pkg::sat32(80'($signed(b3_vm[i]))
                    + bpp_pkg::rnd16(80'(b3_c1[i]) - 80'(b3_c2[i])));
      end
      b4_kick <= b3_kick;
      b4_pos  <= b3_pos;
      for (int i = 0; i < 3; i++) begin
        b5_vn[i] <= bpp_pkg::sat32(80'($signed(b4_vp[i])) + 80'($signed(b4_kick[i])));
      end
      b5_pos <= b4_pos;
      for (int i = 0; i < 3; i++) begin
        b6_p[i] <= bpp_pkg::mul32s($signed({1'b0, time_step}), $signed(b5_vn[i]));
      end
      b6_vn  <= b5_vn;
      b6_pos <= b5_pos;
      for (int i = 0; i < 3; i++) begin
        b7_np[i] <= bpp_pkg::sat32(80'($signed(b6_pos[i]))
                    + 80'($signed(bpp_pkg::qmul(b6_p[i]))));
      end
      b7_vn  <= b6_vn;
      b7_pos <= b6_pos;
      for (int i = 0; i < 3; i++) begin
        b_res.st[i] <= bpp_pkg::sat32(80'($signed(b7_np[i])) - 80'($signed(b7_pos[i])));
      end
      b_res.np <= b7_np;
      b_res.vn <= b7_vn;
    end
  end

endmodule

>>> hdl/boris_particle_push_core.sv
// Boris particle push core: top level with the output register and skid word.
// Depends on bpp_pkg, bpp_qp_unit, bpp_front, bpp_fac_div and bpp_back.
//
//   channel | handshake                 | word
//   --------+---------------------------+------------------------------------------
//   in      | in_valid / in_stall       | pos_*, vel_*, efield_*, bfield_*
//   out     | out_valid / out_stall     | new_pos_*, new_vel_*, step_*
//   cfg     | cfg_write (no handshake)  | cfg_index, cfg_data
//
// One particle word is taken every cycle while in_stall is low; the path to the output
// register runs through five front stages, the 18-stage rotation-factor divider (one
// quotient bit per stage), eight back stages and the output register.
// After reset and after each configuration write, qp is rebuilt by a 64-step serial
// divider; in_stall stays high meanwhile.
// A stalled output word is held; the next word lands in the skid register and only
// then does the pipeline freeze and raise in_stall.
module boris_particle_push_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] efield_x,
  input  logic [31:0] efield_y,
  input  logic [31:0] efield_z,
  input  logic [31:0] bfield_x,
  input  logic [31:0] bfield_y,
  input  logic [31:0] bfield_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_vel_x,
  output logic [31:0] new_vel_y,
  output logic [31:0] new_vel_z,
  output logic [31:0] step_x,
  output logic [31:0] step_y,
  output logic [31:0] step_z
);

  bpp_pkg::cfg_t                   cfg;
  logic                            en;
  logic                            f_valid;
  logic [63:0]                     f_num;
  logic [63:0]                     f_den;
  bpp_pkg::side_t                  f_side;
  logic                            d_valid;
  logic [bpp_pkg::DIV_BITS-1:0]    fac;
  bpp_pkg::side_t                  d_side;
  logic                            b_valid;
  bpp_pkg::res_t                   b_res;
  bpp_pkg::res_t                   out_word;
  bpp_pkg::res_t                   skid;
  logic                            skid_valid;
  bpp_pkg::vec_t                   pos, vel, ef, bf;

  assign pos = {pos_z, pos_y, pos_x};
  assign vel = {vel_z, vel_y, vel_x};
  assign ef  = {efield_z, efield_y, efield_x};
  assign bf  = {bfield_z, bfield_y, bfield_x};

  // Freeze the pipeline only once the skid word is taken
  assign en       = !skid_valid;
  assign in_stall = cfg.busy || skid_valid;

  bpp_qp_unit u_qp (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .cfg
  );

  bpp_front u_front (
    .clk, .rst, .en,
    .in_valid (in_valid && !in_stall),
    .pos, .vel, .ef, .bf,
    .qp       (cfg.qp),
    .f_valid, .f_num, .f_den, .f_side
  );

  bpp_fac_div u_div (
    .clk, .rst, .en,
    .d_in_valid (f_valid),
    .num        (f_num),
    .den        (f_den),
    .d_in_side  (f_side),
    .d_valid, .fac, .d_side
  );

  bpp_back u_back (
    .clk, .rst, .en,
    .b_in_valid (d_valid),
    .fac,
    .side       (d_side),
    .time_step  (cfg.time_step),
    .b_valid, .b_res
  );

  // Output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || (en && b_valid);
      skid_valid <= 1'b0;
    end else if (en && b_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_word <= skid_valid ? skid : b_res;
    end else if (en && b_valid) begin
      skid <= b_res;
    end
  end

  assign new_pos_x = out_word.np[0];
  assign new_pos_y = out_word.np[1];
  assign new_pos_z = out_word.np[2];
  assign new_vel_x = out_word.vn[0];
  assign new_vel_y = out_word.vn[1];
  assign new_vel_z = out_word.vn[2];
  assign step_x    = out_word.st[0];
  assign step_y    = out_word.st[1];
  assign step_z    = out_word.st[2];

  // Skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word without output word");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall && b_valid))
    else $error("skid filled without a stalled output");

  // A configuration write must block input until qp is rebuilt
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("input open right after configuration write");

endmodule
